### hw/rtl/dts_pkg.sv
// Shared types and constants for the duration text parser.
package dts_pkg;

  localparam int NUM_W  = 33;
  localparam int TOT_W  = 40;
  localparam int MULT_W = 25;
  localparam int SEC_W  = 32;
  localparam int WGT_W  = 4;

  localparam logic [NUM_W-1:0]  NUMBER_CAP = '1;
  localparam logic [TOT_W-1:0]  TOTAL_CAP  = '1;
  localparam logic [TOT_W-1:0]  INT32_TOP  = 40'd2147483647;
  localparam logic [WGT_W-1:0]  WEIGHT_CAP = '1;

  localparam logic [MULT_W-1:0] SEC_ONE    = 25'd1;
  localparam logic [MULT_W-1:0] SEC_MINUTE = 25'd60;
  localparam logic [MULT_W-1:0] SEC_HOUR   = 25'd3600;
  localparam logic [MULT_W-1:0] SEC_DAY    = 25'd86400;
  localparam logic [MULT_W-1:0] SEC_WEEK   = 25'd604800;
  localparam logic [MULT_W-1:0] SEC_MONTH  = 25'd2678400;
  localparam logic [MULT_W-1:0] SEC_YEAR   = 25'd31536000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_Y     = 8'h59;

  typedef enum logic [2:0] {
    POS_START       = 3'b001,
    POS_AFTER_MINUS = 3'b010,
    POS_BODY        = 3'b100
  } pos_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    pos_t              position;
    logic              negative;
    logic              time_mode;
    logic              have_number;
    logic              digit_run;
    logic [NUM_W-1:0]  number;
    logic [TOT_W-1:0]  total;
    logic [WGT_W-1:0]  weight;
    status_t           error_code;
  } dts_state_t;

  localparam dts_state_t STATE_CLEAR = '{
    position:    POS_START,
    negative:    1'b0,
    time_mode:   1'b0,
    have_number: 1'b0,
    digit_run:   1'b0,
    number:      '0,
    total:       '0,
    weight:      '0,
    error_code:  ST_OK
  };

  typedef struct packed {
    logic                    done;
    logic signed [SEC_W-1:0] seconds;
    status_t                 status;
    logic [WGT_W-1:0]        weight;
  } dts_result_t;

endpackage

### hw/rtl/dts_step.sv
// Next-state and result logic for one character of duration text.
module dts_step (
  input  dts_pkg::dts_state_t  cur,
  input  logic [7:0]           ch,
  output dts_pkg::dts_state_t  nxt,
  output dts_pkg::dts_result_t res
);
  import dts_pkg::*;

  logic                     is_digit;
  logic [3:0]               digit;
  logic                     body;
  logic                     unit_hit;
  logic [MULT_W-1:0]        mult;
  logic [1:0]               wadd;
  logic [NUM_W+MULT_W-1:0]  prod;
  logic [NUM_W+MULT_W:0]    tsum;
  logic [NUM_W+3:0]         grown;
  logic [WGT_W:0]           wsum;
  logic [TOT_W:0]           fsum;
  logic [TOT_W:0]           limit;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit    = ch[3:0];
  assign prod     = (NUM_W+MULT_W)'(cur.number) * (NUM_W+MULT_W)'(mult);
  assign tsum     = (NUM_W+MULT_W+1)'(cur.total) + (NUM_W+MULT_W+1)'(prod);
  assign grown    = (NUM_W+4)'(cur.number) * (NUM_W+4)'(10) + (NUM_W+4)'(digit);
  assign wsum     = (WGT_W+1)'(cur.weight) + (WGT_W+1)'(wadd);
  assign fsum     = (TOT_W+1)'(cur.total) + (TOT_W+1)'(cur.number);
  assign limit    = (TOT_W+1)'(INT32_TOP) + (TOT_W+1)'(cur.negative);

  // Unit letter decode
  always_comb begin
    unit_hit = 1'b1;
    mult     = SEC_ONE;
    wadd     = 2'd0;
    unique case (ch)
      CH_S: mult = SEC_ONE;
      CH_H: mult = SEC_HOUR;
      CH_D: mult = SEC_DAY;
      CH_W: mult = SEC_WEEK;
      CH_M: begin
        if (cur.time_mode) begin
          mult = SEC_MINUTE;
        end else begin
          mult = SEC_MONTH;
          wadd = 2'd1;
        end
      end
      CH_Y: begin
        mult = SEC_YEAR;
        wadd = 2'd2;
      end
      default: unit_hit = 1'b0;
    endcase
  end

  always_comb begin
    nxt         = cur;
    body        = 1'b0;
    res.done    = 1'b0;
    res.seconds = '0;
    res.status  = cur.error_code;
    res.weight  = '0;

    if (ch == CH_NUL) begin
      res.done = 1'b1;
      if (cur.position == POS_START) begin
        res.status = ST_EMPTY;
      end else if (cur.error_code == ST_OK) begin
        if (fsum > limit) begin
          res.status = ST_OVERFLOW;
        end else begin
          res.seconds = cur.negative ? SEC_W'(32'd0 - fsum[SEC_W-1:0]) : fsum[SEC_W-1:0];
          res.weight  = cur.weight;
        end
      end
      nxt = STATE_CLEAR;
    end else if (cur.error_code == ST_OK) begin
      unique case (cur.position)
        POS_START: begin
          if (ch == CH_MINUS) begin
            nxt.negative = 1'b1;
            nxt.position = POS_AFTER_MINUS;
          end else begin
            nxt.position = POS_BODY;
            body         = (ch != CH_P);
          end
        end
        POS_AFTER_MINUS: begin
          nxt.position = POS_BODY;
          body         = (ch != CH_P);
        end
        POS_BODY: body = 1'b1;
        default:  body = 1'b0;
      endcase

      if (body) begin
        if (is_digit) begin
          if (cur.number == '0) begin
            if (cur.total >= INT32_TOP) begin
              nxt.error_code = ST_OVERFLOW;
            end else begin
              nxt.number      = NUM_W'(digit);
              nxt.have_number = 1'b1;
              nxt.digit_run   = 1'b1;
            end
          end else if (cur.digit_run) begin
            nxt.number = (grown > (NUM_W+4)'(NUMBER_CAP)) ? NUMBER_CAP : grown[NUM_W-1:0];
          end
        end else begin
          nxt.digit_run = 1'b0;
          if (unit_hit) begin
            if (!cur.have_number) begin
              nxt.error_code = ST_SYNTAX;
            end else begin
              nxt.total       = (tsum > (NUM_W+MULT_W+1)'(TOTAL_CAP)) ? TOTAL_CAP
                                                                      : tsum[TOT_W-1:0];
              nxt.number      = '0;
              nxt.have_number = 1'b0;
              nxt.weight      = (wsum > (WGT_W+1)'(WEIGHT_CAP)) ? WEIGHT_CAP
                                                                : wsum[WGT_W-1:0];
            end
          end else if (ch == CH_T) begin
            nxt.time_mode = 1'b1;
          end else begin
            nxt.error_code = ST_SYNTAX;
          end
        end
      end
    end
  end

endmodule

### hw/rtl/duration_text_to_seconds.sv
// Duration text parser top level: character stream in, seconds result out.
//
//  channel | dir | beat contents (tdata, lowest bit first)
//  s_*     | in  | character[7:0]
//  m_*     | out | seconds[31:0], status[33:32], approx_weight[37:34], zero[39:38]
//
// Takes one character every cycle while s_tready is high; state updates in that cycle.
// A zero character loads the result register at the edge that takes it; m_tvalid
// is high from the next cycle on.
// s_tready falls only while a result waits in the output register and m_tready is low.
// rst clears the parse state and the output valid; no clearing pass is needed.
module duration_text_to_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // character[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // seconds[31:0], status[33:32], approx_weight[37:34]
);
  import dts_pkg::*;

  dts_state_t  state;
  dts_state_t  state_next;
  dts_result_t res;
  logic        accept;

  logic signed [SEC_W-1:0] seconds;
  status_t                 status;
  logic [WGT_W-1:0]        approx_weight;

  dts_step u_step (
    .cur (state),
    .ch  (s_tdata),
    .nxt (state_next),
    .res (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Hold the result until the far side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.done) begin
      seconds       <= res.seconds;
      status        <= res.status;
      approx_weight <= res.weight;
    end
  end

  assign m_tdata = {2'b00, approx_weight, status, seconds};

endmodule

### hw/rtl/dts_checker.sv
// Port-level checks for the duration text parser, bound to the top level.
module dts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import dts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] != ST_OK) |-> (m_tdata[31:0] == '0) && (m_tdata[37:34] == '0))
    else $error("non-ok result carries seconds or weight");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata == CH_NUL) |=> m_tvalid)
    else $error("terminator gave no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata != CH_NUL) && m_tready |=> !m_tvalid)
    else $error("result without terminator");

endmodule

bind duration_text_to_seconds dts_checker u_dts_checker (.*);
